// ----- rtl/smac_pkg.sv -----
`timescale 1ns / 1ps
package smac_pkg;

	localparam int DEF_GRANULE_SHIFT = 4;
	localparam int DEF_SHADOW_DEPTH = 17133088;

	localparam int NUM_REGIONS = 6;
	// granule positions up to twice the total map at the finest granule
	localparam int GPOS_W = 26;
	localparam int WORD_W = 64;
	localparam int WORD_SEL_W = $clog2(WORD_W);
	localparam int WPTR_W = GPOS_W - WORD_SEL_W;

	localparam logic [1:0] CMD_CHECK = 2'd0;
	localparam logic [1:0] CMD_POISON = 2'd1;
	localparam logic [1:0] CMD_UNPOISON = 2'd2;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_WRAP = 3'd1;
	localparam logic [2:0] ST_OUTSIDE = 3'd2;
	localparam logic [2:0] ST_POISONED = 3'd3;
	localparam logic [2:0] ST_IGNORED = 3'd4;
	localparam logic [2:0] NO_REGION = 3'd6;

	// peripheral windows, upper limits exclusive
	localparam logic [31:0] WIN0_LO = 32'hE000_0000;
	localparam logic [32:0] WIN0_HI = 33'h0_E010_0000;
	localparam logic [31:0] WIN1_LO = 32'h4000_0000;
	localparam logic [32:0] WIN1_HI = 33'h0_6000_0000;

	typedef struct packed {
		logic load;
		logic match;
		logic span;
		logic pos;
		logic bound;
		logic words;
		logic clr;
		logic rd;
		logic mod;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic clear_last;
		logic need_walk;
		logic empty;
		logic walk_end;
	} dp_stat_t;

	function automatic logic [31:0] region_start(input logic [2:0] r);
		logic [31:0] s;
		unique case (r)
			3'd0: s = 32'h1000_0000;
			3'd1: s = 32'h1100_0000;
			3'd2: s = 32'h1200_0000;
			3'd3: s = 32'h3000_0000;
			3'd4: s = 32'h3100_0000;
			3'd5: s = 32'h7000_0000;
			default: s = '0;
		endcase
		return s;
	endfunction

	function automatic logic [31:0] region_bytes(input logic [2:0] r);
		logic [31:0] s;
		unique case (r)
			3'd0: s = 32'h0008_0000;
			3'd1: s = 32'h0002_0000;
			3'd2: s = 32'h0020_0000;
			3'd3: s = 32'h0008_0000;
			3'd4: s = 32'h0020_0000;
			3'd5: s = 32'h1000_0000;
			default: s = '0;
		endcase
		return s;
	endfunction

	function automatic logic [GPOS_W-1:0] gran_count(input logic [2:0] r, input int gs);
		logic [32:0] t;
		t = {1'b0, region_bytes(r)} + ((33'd1 << gs) - 33'd1);
		return GPOS_W'(t >> gs);
	endfunction

	// granules of all earlier regions, packed back to back
	function automatic logic [GPOS_W-1:0] region_base(input logic [2:0] r, input int gs);
		logic [GPOS_W-1:0] b;
		b = '0;
		for (int i = 0; i < NUM_REGIONS; i++) begin
			if (3'(i) < r) begin
				b = b + gran_count(3'(i), gs);
			end
		end
		return b;
	endfunction

endpackage

// ----- rtl/smac_req_if.sv -----
`timescale 1ns / 1ps
interface smac_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [31:0] address;
	logic [31:0] length;

	modport source (output valid, output command, output address, output length, input ready);
	modport sink (input valid, input command, input address, input length, output ready);
endinterface

// ----- rtl/smac_rsp_if.sv -----
`timescale 1ns / 1ps
interface smac_rsp_if;
	logic       valid;
	logic       ready;
	logic [2:0] status;
	logic [2:0] region_index;

	modport source (output valid, output status, output region_index, input ready);
	modport sink (input valid, input status, input region_index, output ready);
endinterface

// ----- rtl/smac_ctrl.sv -----
`timescale 1ns / 1ps
module smac_ctrl import smac_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output dp_cmd_t  cmd,
	input  dp_stat_t stat
);

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_MATCH,
		S_SPAN,
		S_POS,
		S_BOUND,
		S_WORDS,
		S_READ,
		S_MOD,
		S_DONE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   in_fire;
	logic   out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_CLEAR: cmd.clr      = 1'b1;
			S_IDLE:  cmd.load     = in_fire;
			S_MATCH: cmd.match    = 1'b1;
			S_SPAN:  cmd.span     = 1'b1;
			S_POS:   cmd.pos      = 1'b1;
			S_BOUND: cmd.bound    = 1'b1;
			S_WORDS: cmd.words    = 1'b1;
			S_READ:  cmd.rd       = 1'b1;
			S_MOD:   cmd.mod      = 1'b1;
			S_DONE:  cmd.out_load = out_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					if (stat.clear_last) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_fire) begin
						state_q <= S_MATCH;
					end
				end
				S_MATCH: state_q <= S_SPAN;
				S_SPAN:  state_q <= stat.need_walk ? S_POS : S_DONE;
				S_POS:   state_q <= S_BOUND;
				S_BOUND: state_q <= S_WORDS;
				S_WORDS: state_q <= stat.empty ? S_DONE : S_READ;
				S_READ:  state_q <= S_MOD;
				S_MOD:   state_q <= stat.walk_end ? S_DONE : S_READ;
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> state_q == S_MATCH)
		else $error("transfer in did not start decode");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("result raised outside done state");

	a_walk_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MOD && !stat.walk_end) |=> state_q == S_READ)
		else $error("word walk stopped early");

endmodule

// ----- rtl/smac_dpath.sv -----
`timescale 1ns / 1ps
module smac_dpath import smac_pkg::*; #(
	parameter int GRANULE_SHIFT = DEF_GRANULE_SHIFT,
	parameter int SHADOW_DEPTH  = DEF_SHADOW_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  dp_cmd_t     cmd,
	output dp_stat_t    stat,
	input  logic        enabled,
	input  logic [1:0]  command,
	input  logic [31:0] address,
	input  logic [31:0] length,
	output logic [2:0]  status,
	output logic [2:0]  region_index
);

	localparam int SHADOW_WORDS = (SHADOW_DEPTH + WORD_W - 1) / WORD_W;
	localparam int WORD_AW = $clog2(SHADOW_WORDS);
	localparam logic [32:0] GRAN_MASK = 33'((64'd1 << GRANULE_SHIFT) - 64'd1);
	localparam logic [GPOS_W-1:0] DEPTH_POS = GPOS_W'(SHADOW_DEPTH);
	localparam logic [WPTR_W-1:0] LAST_WORD = WPTR_W'(SHADOW_WORDS - 1);
	localparam logic [WORD_SEL_W-1:0] TOP_BIT = WORD_SEL_W'(WORD_W - 1);

	logic [WORD_W-1:0] mem [SHADOW_WORDS];

	logic [1:0]            cmd_q;
	logic [31:0]           addr_q;
	logic [31:0]           len_q;
	logic [31:0]           end_q;
	logic [2:0]            reg_q;
	logic [2:0]            res_status_q;
	logic [2:0]            res_region_q;
	logic                  need_walk_q;
	logic [31:0]           offlo_q;
	logic [32:0]           offhi_q;
	logic [GPOS_W-1:0]     lo_q;
	logic [GPOS_W-1:0]     hi_q;
	logic [GPOS_W-1:0]     glo_q;
	logic [GPOS_W-1:0]     ghi_q;
	logic [WPTR_W-1:0]     ptr_q;
	logic [WPTR_W-1:0]     first_q;
	logic [WPTR_W-1:0]     last_q;
	logic [WORD_SEL_W-1:0] first_bit_q;
	logic [WORD_SEL_W-1:0] last_bit_q;
	logic [WORD_W-1:0]     rd_q;
	logic [2:0]            out_status_q;
	logic [2:0]            out_region_q;

	logic [32:0]            sum;
	logic [31:0]            end_c;
	logic                   wrap;
	logic                   in_win;
	logic [NUM_REGIONS-1:0] hit;
	logic [2:0]             reg_c;
	logic [2:0]             st_c;
	logic [2:0]             rg_c;
	logic                   walk_c;
	logic                   len_zero;

	logic [31:0]       start_s;
	logic [31:0]       lo_full;
	logic [32:0]       hi_full;
	logic [GPOS_W-1:0] cnt;
	logic [GPOS_W-1:0] hi_c;
	logic [GPOS_W-1:0] lo_c;
	logic [GPOS_W-1:0] base;
	logic [GPOS_W-1:0] glo;
	logic [GPOS_W-1:0] ghi;
	logic [GPOS_W-1:0] hm1;

	logic [WORD_W-1:0] lo_mask;
	logic [WORD_W-1:0] hi_mask;
	logic [WORD_W-1:0] mask;
	logic [WORD_W-1:0] wdata;
	logic              word_hit;
	logic [WORD_AW-1:0] idx;

	// request classification: end address, windows, regions
	always_comb begin
		sum      = {1'b0, addr_q} + {1'b0, len_q};
		end_c    = sum[31:0];
		wrap     = sum[32];
		len_zero = (len_q == '0);
		in_win   = (addr_q >= WIN0_LO && {1'b0, end_c} <= WIN0_HI) ||
		           (addr_q >= WIN1_LO && {1'b0, end_c} <= WIN1_HI);
		for (int i = 0; i < NUM_REGIONS; i++) begin
			hit[i] = (addr_q >= region_start(3'(i))) &&
			         ({1'b0, end_c} <= ({1'b0, region_start(3'(i))} +
			                            {1'b0, region_bytes(3'(i))}));
		end
		reg_c = NO_REGION;
		for (int i = NUM_REGIONS - 1; i >= 0; i--) begin
			if (hit[i]) begin
				reg_c = 3'(i);
			end
		end
		st_c   = ST_IGNORED;
		rg_c   = NO_REGION;
		walk_c = 1'b0;
		case (cmd_q) inside
			CMD_CHECK: begin
				st_c = ST_OK;
				if (enabled && !in_win) begin
					if (wrap) begin
						st_c = ST_WRAP;
					end else if (!(|hit)) begin
						st_c = ST_OUTSIDE;
					end else begin
						rg_c = reg_c;
						if (len_zero) begin
							st_c = ST_POISONED;
						end else begin
							walk_c = 1'b1;
						end
					end
				end
			end
			CMD_POISON, CMD_UNPOISON: begin
				if (enabled && !wrap && (|hit)) begin
					st_c   = ST_OK;
					rg_c   = reg_c;
					walk_c = !len_zero;
				end
			end
			default: begin
				st_c = ST_IGNORED;
			end
		endcase
	end

	// granule span of the chosen region
	always_comb begin
		start_s = region_start(reg_q);
		lo_full = offlo_q >> GRANULE_SHIFT;
		hi_full = offhi_q >> GRANULE_SHIFT;
		cnt     = gran_count(reg_q, GRANULE_SHIFT);
		hi_c    = (hi_full > 33'(cnt)) ? cnt : hi_full[GPOS_W-1:0];
		lo_c    = ({1'b0, lo_full} > 33'(hi_c)) ? hi_c : lo_full[GPOS_W-1:0];
		base    = region_base(reg_q, GRANULE_SHIFT);
		glo     = lo_q + base;
		ghi     = hi_q + base;
		hm1     = ghi_q - GPOS_W'(1);
	end

	// per-word bit mask and read-modify-write data
	always_comb begin
		lo_mask  = (ptr_q == first_q) ? ({WORD_W{1'b1}} << first_bit_q) : {WORD_W{1'b1}};
		hi_mask  = (ptr_q == last_q) ? ({WORD_W{1'b1}} >> (TOP_BIT - last_bit_q))
		                             : {WORD_W{1'b1}};
		mask     = lo_mask & hi_mask;
		word_hit = |(rd_q & mask);
		wdata    = (cmd_q == CMD_POISON) ? (rd_q | mask) : (rd_q & ~mask);
		idx      = ptr_q[WORD_AW-1:0];
	end

	assign stat.clear_last = (ptr_q == LAST_WORD);
	assign stat.need_walk  = need_walk_q;
	assign stat.empty      = (glo_q >= ghi_q);
	assign stat.walk_end   = (ptr_q == last_q) || (cmd_q == CMD_CHECK && word_hit);

	assign status       = out_status_q;
	assign region_index = out_region_q;

	// word pointer: clearing sweep and range walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
		end else if (cmd.words) begin
			ptr_q <= glo_q[GPOS_W-1:WORD_SEL_W];
		end else if (cmd.clr || cmd.mod) begin
			ptr_q <= ptr_q + WPTR_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q  <= command;
			addr_q <= address;
			len_q  <= length;
		end
		if (cmd.match) begin
			end_q        <= end_c;
			reg_q        <= reg_c;
			res_status_q <= st_c;
			res_region_q <= rg_c;
			need_walk_q  <= walk_c;
		end
		if (cmd.span) begin
			offlo_q <= addr_q - start_s;
			offhi_q <= {1'b0, end_q} - {1'b0, start_s} + GRAN_MASK;
		end
		if (cmd.pos) begin
			lo_q <= lo_c;
			hi_q <= hi_c;
		end
		if (cmd.bound) begin
			glo_q <= glo;
			ghi_q <= (ghi > DEPTH_POS) ? DEPTH_POS : ghi;
		end
		if (cmd.words) begin
			first_q     <= glo_q[GPOS_W-1:WORD_SEL_W];
			last_q      <= hm1[GPOS_W-1:WORD_SEL_W];
			first_bit_q <= glo_q[WORD_SEL_W-1:0];
			last_bit_q  <= hm1[WORD_SEL_W-1:0];
		end
		if (cmd.mod && cmd_q == CMD_CHECK && word_hit) begin
			res_status_q <= ST_POISONED;
		end
		if (cmd.out_load) begin
			out_status_q <= res_status_q;
			out_region_q <= res_region_q;
		end
	end

	// shadow store, one read or one write per cycle
	always_ff @(posedge clk) begin
		if (cmd.clr) begin
			mem[idx] <= '0;
		end else if (cmd.mod && cmd_q != CMD_CHECK) begin
			mem[idx] <= wdata;
		end
		if (cmd.rd) begin
			rd_q <= mem[idx];
		end
	end

	a_walk_upper: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd |-> ptr_q <= last_q)
		else $error("shadow read past end of range");

	a_walk_lower: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd |-> ptr_q >= first_q)
		else $error("shadow read before start of range");

	a_no_region_code: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_load && (res_status_q == ST_WRAP || res_status_q == ST_OUTSIDE ||
		                  res_status_q == ST_IGNORED)) |-> res_region_q == NO_REGION)
		else $error("region index given with a failing status");

endmodule

// ----- rtl/shadow_memory_access_checker.sv -----
// channel  modport  payload                              transfer when
// req      sink     command[1:0] address[31:0] length    req.valid && req.ready
// rsp      source   status[2:0] region_index[2:0]        rsp.valid && rsp.ready
// cfg      write    cfg_wr_data (enable bit)             cfg_wr_en
//
// one request at a time; with no shadow access a request passes the match, span and done states,
//   and the result turns valid as the controller returns to idle to take the next request
// a range walk passes the match, span, pos, bound and words states, then a read and a modify/write
//   state for each 64-bit shadow word; a check stops at the first word with a poisoned granule
// the single-port shadow word store sets the rate
// after reset a clearing sweep over all ceil(SHADOW_DEPTH / 64) shadow words (267705 at the defaults)
//   runs with req.ready low; configuration writes are taken throughout
// a held result waits in the output register while the next request is taken
`timescale 1ns / 1ps
module shadow_memory_access_checker import smac_pkg::*; #(
	parameter int GRANULE_SHIFT = DEF_GRANULE_SHIFT,
	parameter int SHADOW_DEPTH  = DEF_SHADOW_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	smac_req_if.sink          req,
	smac_rsp_if.source        rsp,
	input  logic              cfg_wr_en,
	input  logic              cfg_wr_data
);

	// enable register: when low, checks pass and range marking is ignored
	logic     checker_enabled_q;
	dp_cmd_t  cmd;
	dp_stat_t stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			checker_enabled_q <= 1'b0;
		end else if (cfg_wr_en) begin
			checker_enabled_q <= cfg_wr_data;
		end
	end

	// sequencer: clearing sweep, decode steps, word walk, result hand-off
	smac_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	// address decode, granule span arithmetic and the shadow bit store
	smac_dpath #(
		.GRANULE_SHIFT (GRANULE_SHIFT),
		.SHADOW_DEPTH  (SHADOW_DEPTH)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.enabled      (checker_enabled_q),
		.command      (req.command),
		.address      (req.address),
		.length       (req.length),
		.status       (rsp.status),
		.region_index (rsp.region_index)
	);

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
module tb;
	import smac_pkg::*;

	localparam int GSHIFT = DEF_GRANULE_SHIFT;
	localparam int SHADOW_BITS = DEF_SHADOW_DEPTH;
	localparam int SHADOW_WORDS = (SHADOW_BITS + 63) / 64;
	localparam int WATCHDOG_LIMIT = 2000000;
	localparam int ITEMS_PER_PHASE = 88;
	localparam int NUM_PHASES = 8;
	localparam int HOLD_OFF_CYCLES = 600;

	// the one command value the block does not define
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	// region map, region r at bits [r*32 +: 32]
	localparam logic [191:0] MAP_START = {32'h7000_0000, 32'h3100_0000, 32'h3000_0000,
		32'h1200_0000, 32'h1100_0000, 32'h1000_0000};
	localparam logic [191:0] MAP_SIZE = {32'h1000_0000, 32'h0020_0000, 32'h0008_0000,
		32'h0020_0000, 32'h0002_0000, 32'h0008_0000};
	// peripheral windows, window w at bits [w*32 +: 32], upper limit exclusive
	localparam logic [63:0] WIN_LO = {32'h4000_0000, 32'hE000_0000};
	localparam logic [63:0] WIN_HI = {32'h6000_0000, 32'hE010_0000};

	localparam bit KNOWN = 1'b1;
	localparam bit PREDICTED = 1'b0;

	typedef struct packed {
		logic [2:0] status;
		logic [2:0] region;
	} verdict_t;

	typedef struct packed {
		bit en;
		logic [1:0] cmd;
		logic [31:0] addr;
		logic [31:0] len;
		bit known;
		verdict_t want;
	} stim_row_t;

	// directed requests; a row marked KNOWN carries its verdict, the rest go to the predictor
	stim_row_t directed_rows [0:30] = '{
		// disabled: checks pass, marking and the unused command are ignored
		'{1'b0, CMD_CHECK, 32'h1000_0000, 32'h0000_0010, KNOWN, '{ST_OK, NO_REGION}},
		'{1'b0, CMD_POISON, 32'h1000_0000, 32'h0000_0010, KNOWN, '{ST_IGNORED, NO_REGION}},
		'{1'b0, CMD_CHECK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, KNOWN, '{ST_OK, NO_REGION}},
		'{1'b0, CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, KNOWN, '{ST_IGNORED, NO_REGION}},
		// enabled: single granule poison and neighbors
		'{1'b1, CMD_CHECK, 32'h1000_0000, 32'h0000_0010, KNOWN, '{ST_OK, 3'd0}},
		'{1'b1, CMD_POISON, 32'h1000_0020, 32'h0000_0001, KNOWN, '{ST_OK, 3'd0}},
		'{1'b1, CMD_CHECK, 32'h1000_002F, 32'h0000_0001, KNOWN, '{ST_POISONED, 3'd0}},
		'{1'b1, CMD_CHECK, 32'h1000_0010, 32'h0000_0010, KNOWN, '{ST_OK, 3'd0}},
		'{1'b1, CMD_CHECK, 32'h1000_0011, 32'h0000_0010, KNOWN, '{ST_POISONED, 3'd0}},
		// zero length: a check fails, a mark marks nothing
		'{1'b1, CMD_CHECK, 32'h1100_0000, 32'h0000_0000, KNOWN, '{ST_POISONED, 3'd1}},
		'{1'b1, CMD_POISON, 32'h1100_0008, 32'h0000_0000, KNOWN, '{ST_OK, 3'd1}},
		'{1'b1, CMD_CHECK, 32'h1100_0000, 32'h0000_0010, KNOWN, '{ST_OK, 3'd1}},
		// window test wins over the wrap test
		'{1'b1, CMD_CHECK, 32'hFFFF_FFFF, 32'h0000_0002, KNOWN, '{ST_OK, NO_REGION}},
		'{1'b1, CMD_CHECK, 32'h3000_0000, 32'hE000_0000, KNOWN, '{ST_WRAP, NO_REGION}},
		'{1'b1, CMD_CHECK, 32'hE000_0000, 32'h0010_0000, KNOWN, '{ST_OK, NO_REGION}},
		'{1'b1, CMD_CHECK, 32'h4000_0000, 32'h2000_0000, KNOWN, '{ST_OK, NO_REGION}},
		'{1'b1, CMD_CHECK, 32'h5FFF_FFFF, 32'h0000_0002, KNOWN, '{ST_OUTSIDE, NO_REGION}},
		// region end exactly reached, then crossed
		'{1'b1, CMD_CHECK, 32'h1007_FFF0, 32'h0000_0010, KNOWN, '{ST_OK, 3'd0}},
		'{1'b1, CMD_CHECK, 32'h1007_FFF0, 32'h0000_0011, KNOWN, '{ST_OUTSIDE, NO_REGION}},
		'{1'b1, CMD_CHECK, 32'h0000_0000, 32'hFFFF_FFFF, KNOWN, '{ST_OUTSIDE, NO_REGION}},
		// whole largest region, stops at its first poisoned granule
		'{1'b1, CMD_POISON, 32'h7000_0000, 32'h0000_0001, KNOWN, '{ST_OK, 3'd5}},
		'{1'b1, CMD_CHECK, 32'h7000_0000, 32'h1000_0000, KNOWN, '{ST_POISONED, 3'd5}},
		'{1'b1, CMD_UNPOISON, 32'h7000_0000, 32'h0000_0010, KNOWN, '{ST_OK, 3'd5}},
		// marking ignored: wrapped range, no region, unused command
		'{1'b1, CMD_POISON, 32'h3000_0000, 32'hE000_0000, KNOWN, '{ST_IGNORED, NO_REGION}},
		'{1'b1, CMD_UNPOISON, 32'h2000_0000, 32'h0000_0010, KNOWN, '{ST_IGNORED, NO_REGION}},
		'{1'b1, CMD_UNUSED, 32'h1000_0000, 32'h0000_0010, KNOWN, '{ST_IGNORED, NO_REGION}},
		// whole region marking, then partial unmarking
		'{1'b1, CMD_POISON, 32'h1100_0000, 32'h0002_0000, KNOWN, '{ST_OK, 3'd1}},
		'{1'b1, CMD_CHECK, 32'h1101_FFFF, 32'h0000_0001, PREDICTED, '{ST_OK, NO_REGION}},
		'{1'b1, CMD_UNPOISON, 32'h1100_0008, 32'h0001_0000, PREDICTED, '{ST_OK, NO_REGION}},
		'{1'b1, CMD_CHECK, 32'h3107_FF00, 32'h0000_0100, PREDICTED, '{ST_OK, NO_REGION}},
		'{1'b1, CMD_CHECK, 32'h3007_FFFF, 32'h0000_0001, PREDICTED, '{ST_OK, NO_REGION}}
	};

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en;
	logic cfg_wr_data;

	smac_req_if req_ch();
	smac_rsp_if rsp_ch();

	shadow_memory_access_checker #(
		.GRANULE_SHIFT(GSHIFT),
		.SHADOW_DEPTH(SHADOW_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	// predictor state: enable bit as the block holds it, one poison bit per granule
	bit enable_mirror;
	bit enable_setting;
	bit [63:0] poison_words [SHADOW_WORDS];
	verdict_t verdict_queue [$];

	// what goes with the request on offer
	bit row_known;
	verdict_t row_verdict;

	int send_idle_pct;
	int stall_pct;
	int hold_off_request;
	bit hold_taken;
	int hold_left;
	int quiet_cycles;
	int mismatch_count;
	int requests_taken;
	int config_writes;
	int status_seen [5];
	verdict_t oldest;
	verdict_t predicted;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// verdict for one request; marking commands update the poison bits
	function automatic verdict_t predict_verdict(input logic [1:0] cmd,
		input logic [31:0] addr, input logic [31:0] len);
		verdict_t v;
		logic [31:0] stop_addr;
		logic [31:0] rstart;
		logic [31:0] rsize;
		longint off, lo, hi, cnt, base;
		int r;
		bit in_win;
		bit hit;
		v.status = ST_IGNORED;
		v.region = NO_REGION;
		stop_addr = addr + len;
		// first region holding the whole access; map is searched top down so the lowest wins
		r = -1;
		for (int i = NUM_REGIONS - 1; i >= 0; i--) begin
			if (addr >= MAP_START[i*32 +: 32] &&
				{1'b0, stop_addr} <= {1'b0, MAP_START[i*32 +: 32]} + {1'b0, MAP_SIZE[i*32 +: 32]})
				r = i;
		end
		// granule span touched inside that region, as store positions
		lo = 0;
		hi = 0;
		if (r >= 0) begin
			rstart = MAP_START[r*32 +: 32];
			rsize = MAP_SIZE[r*32 +: 32];
			base = 0;
			for (int i = 0; i < r; i++)
				base += ({32'd0, MAP_SIZE[i*32 +: 32]} + (64'd1 << GSHIFT) - 1) >> GSHIFT;
			cnt = ({32'd0, rsize} + (64'd1 << GSHIFT) - 1) >> GSHIFT;
			off = {32'd0, addr} - {32'd0, rstart};
			lo = off >> GSHIFT;
			hi = (off + {32'd0, len} + (64'd1 << GSHIFT) - 1) >> GSHIFT;
			if (hi > cnt)
				hi = cnt;
			if (len == 0 || lo > hi)
				lo = hi;
			lo += base;
			hi += base;
			if (hi > SHADOW_BITS)
				hi = SHADOW_BITS;
		end
		case (cmd)
			CMD_CHECK: begin
				v.status = ST_OK;
				if (enable_mirror) begin
					in_win = 1'b0;
					for (int w = 0; w < 2; w++) begin
						if (addr >= WIN_LO[w*32 +: 32] && stop_addr <= WIN_HI[w*32 +: 32])
							in_win = 1'b1;
					end
					if (!in_win) begin
						if (stop_addr < addr) begin
							v.status = ST_WRAP;
						end else if (r < 0) begin
							v.status = ST_OUTSIDE;
						end else begin
							v.region = 3'(r);
							// an empty access counts as poisoned
							hit = (len == 0);
							for (longint g = lo; g < hi && !hit; g++)
								hit = poison_words[g >> 6][g[5:0]];
							v.status = hit ? ST_POISONED : ST_OK;
						end
					end
				end
			end
			CMD_POISON, CMD_UNPOISON: begin
				if (enable_mirror && stop_addr >= addr && r >= 0) begin
					v.status = ST_OK;
					v.region = 3'(r);
					for (longint g = lo; g < hi; g++)
						poison_words[g >> 6][g[5:0]] = (cmd == CMD_POISON);
				end
			end
			default: begin
			end
		endcase
		return v;
	endfunction

	task automatic note_mismatch(input string what, input verdict_t want, input verdict_t got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("mismatch (%s) at %0t: expected status %0d region %0d, got status %0d region %0d",
				what, $realtime, want.status, want.region, got.status, got.region);
	endtask

	// scoreboard: both channels sampled at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_wr_en) begin
				enable_mirror = cfg_wr_data;
				config_writes++;
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (rsp_ch.status <= ST_IGNORED)
					status_seen[rsp_ch.status]++;
				if (verdict_queue.size() == 0) begin
					note_mismatch("result with no request", '0, {rsp_ch.status, rsp_ch.region_index});
				end else begin
					oldest = verdict_queue.pop_front();
					if (rsp_ch.status !== oldest.status || rsp_ch.region_index !== oldest.region)
						note_mismatch("wrong field", oldest, {rsp_ch.status, rsp_ch.region_index});
				end
			end
			if (req_ch.valid && req_ch.ready) begin
				requests_taken++;
				// always run the predictor so the poison bits track the block
				predicted = predict_verdict(req_ch.command, req_ch.address, req_ch.length);
				verdict_queue.push_back(row_known ? row_verdict : predicted);
			end
		end
	end

	// watchdog: cycles in a row with no transfer on either channel
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles, %0d results outstanding",
				quiet_cycles, verdict_queue.size());
			$display("FAIL");
			$finish;
		end
	end

	// receiver: random stalls, or a long hold-off once one is requested
	always @(negedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (hold_off_request != 0 && !hold_taken) begin
				hold_left = hold_off_request;
				hold_taken = 1'b1;
			end
			if (hold_left > 0) begin
				rsp_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// offer one request from a falling edge and return at the falling edge after its transfer
	task automatic offer_request(input logic [1:0] cmd, input logic [31:0] addr,
		input logic [31:0] len, input bit known, input verdict_t fixed);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.command <= cmd;
		req_ch.address <= addr;
		req_ch.length <= len;
		row_known = known;
		row_verdict = fixed;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// enable written only once the block has drained
	task automatic write_enable(input bit value);
		req_ch.valid <= 1'b0;
		while (verdict_queue.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		enable_setting = value;
	endtask

	// mostly in-region traffic near the region edges, some window traffic, some noise
	task automatic make_random_request(output logic [1:0] cmd, output logic [31:0] addr,
		output logic [31:0] len);
		int kind, pick, r, w;
		logic [31:0] rsize;
		logic [31:0] off;
		kind = $urandom_range(99);
		if (kind < 75) begin
			r = $urandom_range(NUM_REGIONS - 1);
			rsize = MAP_SIZE[r*32 +: 32];
			// small hot zones so marks and checks meet often
			if ($urandom_range(3) == 0)
				off = rsize - $urandom_range(32'h1000, 1);
			else
				off = $urandom_range(32'hFFF);
			pick = $urandom_range(99);
			if (pick < 10)
				len = 0;
			else if (pick < 90)
				len = $urandom_range(64, 1);
			else if (pick < 98)
				len = $urandom_range(32'h1000, 1);
			else
				len = $urandom_range(32'h2_0000, 1);
			if (len > rsize - off)
				len = rsize - off;
			addr = MAP_START[r*32 +: 32] + off;
			pick = $urandom_range(99);
			cmd = (pick < 55) ? CMD_CHECK : (pick < 77) ? CMD_POISON : CMD_UNPOISON;
		end else if (kind < 85) begin
			w = $urandom_range(1);
			cmd = ($urandom_range(3) == 0) ? CMD_POISON : CMD_CHECK;
			pick = $urandom_range(2);
			if (pick == 0) begin
				addr = WIN_LO[w*32 +: 32] + $urandom_range(32'hFFFF);
				len = $urandom_range(64);
			end else if (pick == 1) begin
				// near the upper limit, sometimes across it
				addr = WIN_HI[w*32 +: 32] - $urandom_range(32, 1);
				len = $urandom_range(64);
			end else begin
				// wraps past the top; the wrapped end still passes the test of the window at E000_0000
				addr = 32'hFFFF_FFFF - $urandom_range(15);
				len = $urandom_range(32'h20_0000, 1);
			end
		end else begin
			cmd = 2'($urandom_range(3));
			addr = $urandom;
			pick = $urandom_range(99);
			if (pick < 40) begin
				len = $urandom;
			end else if (pick < 70) begin
				len = $urandom_range(255);
			end else begin
				// straddle a region end
				r = $urandom_range(NUM_REGIONS - 1);
				addr = MAP_START[r*32 +: 32] + MAP_SIZE[r*32 +: 32] - $urandom_range(32, 1);
				len = $urandom_range(64, 1);
			end
			// keep long walks out of the largest region
			if (addr[31:28] == 4'h7 && len > 32'h1000)
				addr[31] = 1'b1;
		end
	endtask

	initial begin
		stim_row_t row;
		logic [1:0] cmd;
		logic [31:0] addr;
		logic [31:0] len;
		int errors;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.command = CMD_CHECK;
		req_ch.address = '0;
		req_ch.length = '0;
		send_idle_pct = 0;
		stall_pct = 0;
		hold_off_request = 0;
		enable_setting = 1'b0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// directed part, no idling; the first transfer waits out the clearing sweep
		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			if (row.en != enable_setting)
				write_enable(row.en);
			offer_request(row.cmd, row.addr, row.len, row.known, row.want);
		end

		// random phases cycle through the idling modes; two run with the checker off
		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			write_enable(!(phase == 3 || phase == 6));
			case (phase % 4)
				0: begin send_idle_pct = 0; stall_pct = 0; end
				1: begin send_idle_pct = 64; stall_pct = 0; end
				2: begin send_idle_pct = 0; stall_pct = 64; end
				default: begin send_idle_pct = 32; stall_pct = 32; end
			endcase
			// receiver goes quiet while requests keep coming, so the input backs up
			if (phase == 4)
				hold_off_request = HOLD_OFF_CYCLES;
			repeat (ITEMS_PER_PHASE) begin
				make_random_request(cmd, addr, len);
				offer_request(cmd, addr, len, PREDICTED, '0);
			end
		end

		req_ch.valid <= 1'b0;
		while (verdict_queue.size() != 0)
			@(negedge clk);
		repeat (16) @(negedge clk);

		errors = mismatch_count + verdict_queue.size();
		$display("covered %0d requests in %0d directed rows and %0d random phases, %0d enable writes",
			requests_taken, $size(directed_rows), NUM_PHASES, config_writes);
		$display("results: ok %0d, wrap %0d, outside %0d, poisoned %0d, ignored %0d; mismatches %0d",
			status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4],
			mismatch_count);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
